@@ rtl/grid_mesh_triangulator_normals_macros.svh @@
// ----------------------------------------------------------------------------
// Grid mesh triangulator macros
// Assertion helpers included by the triangulator top module.
// ----------------------------------------------------------------------------
`ifndef GRID_MESH_TRIANGULATOR_NORMALS_MACROS_SVH
`define GRID_MESH_TRIANGULATOR_NORMALS_MACROS_SVH

// cond implies prop in the same cycle
`define GMTN_ASSERT_SAME(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("gmtn: same-cycle check failed");

// cond implies prop in the next cycle
`define GMTN_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("gmtn: next-cycle check failed");

`endif

@@ rtl/gmtn_pkg.sv @@
// ----------------------------------------------------------------------------
// Grid mesh triangulator package
// Shared constants, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package gmtn_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int COORD_BITS_DEF  = 16;

    localparam int CFG_BITS       = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int ROW_LIMIT      = 1024;
    localparam int ROW_BITS       = 11;
    localparam int NORM_BITS      = 16;
    localparam int SRCH_BITS      = 15;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_ROWS    = 2'd1;

    localparam logic [CFG_BITS-1:0] GRID_COLUMNS_RST = 11'd2;
    localparam logic [CFG_BITS-1:0] GRID_ROWS_RST    = 11'd2;

    localparam logic [2:0] LAST_WORD = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_SRCH = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

endpackage

@@ rtl/gmtn_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gmtn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = gmtn_pkg::MAX_COLUMNS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/grid_mesh_triangulator_normals.sv @@
// ----------------------------------------------------------------------------
// Grid mesh triangulator with face normals
// Keeps the previous grid row in a line buffer RAM, and for every vertex that
// closes a quad emits two triangles (six words) with unit face normals.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  in       in_valid/in_ready  vert_x, vert_y, vert_z
//  out      out_valid/out_ready out_x..out_z, norm_x..norm_z, quad_done
//  cfg      cfg_we             cfg_index, cfg_data
//
//  A vertex that closes no quad passes only the accept and line buffer read steps.
//  A closing vertex also runs both normals: one shared multiplier runs the cross
//  product and squares, then a bit-serial search finds each rounded normal
//  component, one bit per cycle.
//  Output stalls only hold the six-word emit phase; reset clears the counters,
//  the held corners and the registers to two columns by two rows.
// ----------------------------------------------------------------------------
module grid_mesh_triangulator_normals #(
    parameter int MAX_COLUMNS = gmtn_pkg::MAX_COLUMNS_DEF,
    parameter int COORD_BITS  = gmtn_pkg::COORD_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [gmtn_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [gmtn_pkg::CFG_BITS-1:0]          cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [COORD_BITS-1:0]           vert_x,
    input  logic signed [COORD_BITS-1:0]           vert_y,
    input  logic signed [COORD_BITS-1:0]           vert_z,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [COORD_BITS-1:0]           out_x,
    output logic signed [COORD_BITS-1:0]           out_y,
    output logic signed [COORD_BITS-1:0]           out_z,
    output logic signed [gmtn_pkg::NORM_BITS-1:0]  norm_x,
    output logic signed [gmtn_pkg::NORM_BITS-1:0]  norm_y,
    output logic signed [gmtn_pkg::NORM_BITS-1:0]  norm_z,
    output logic                                   quad_done
);

    `include "grid_mesh_triangulator_normals_macros.svh"

    localparam int CB  = COORD_BITS;
    localparam int VW  = 3 * CB;
    localparam int D   = CB + 1;
    localparam int PW  = 2 * D + 2;
    localparam int CXW = 2 * D + 1;
    localparam int MW  = 2 * D;
    localparam int SQW = 4 * D;
    localparam int W   = 4 * D + 36;
    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int NB  = gmtn_pkg::NORM_BITS;
    localparam int SB  = gmtn_pkg::SRCH_BITS;

    localparam logic [4:0] MUL_SKIP = 5'd6;
    localparam logic [4:0] MUL_LAST = 5'd16;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    gmtn_pkg::state_t state_reg, state_next;

    logic [gmtn_pkg::CFG_BITS-1:0] grid_columns_reg, grid_rows_reg;
    logic [CW-1:0]                 col_reg;
    logic [gmtn_pkg::ROW_BITS-1:0] row_reg;
    logic                          quad_reg;
    logic                          nsel_reg;
    logic [4:0]                    cnt_reg;
    logic [1:0]                    comp_reg;
    logic                          srch_init_reg;
    logic [3:0]                    kc_reg;
    logic [2:0]                    word_reg;
    logic                          out_valid_reg;

    logic [VW-1:0] v_reg, left_reg, upper_reg;
    logic [VW-1:0] p0_reg, p1_reg, p3_reg;
    logic signed [D-1:0]   e_reg [3];
    logic signed [D-1:0]   f_reg [3];
    logic signed [D-1:0]   g_reg [3];
    logic signed [PW-1:0]  prod_reg;
    logic signed [CXW-1:0] c_reg [3];
    logic [SQW-1:0]        sq_reg [3];
    logic signed [W-1:0]   p_reg, a_reg, b_reg, t_reg;
    logic [SB-1:0]         r_reg;
    logic signed [NB-1:0]  nrm_reg [2][3];

    logic [CB-1:0]        ox_reg, oy_reg, oz_reg;
    logic signed [NB-1:0] nx_reg, ny_reg, nz_reg;
    logic                 done_reg;

    // ------------------------------------------------------------------
    // line buffer
    // ------------------------------------------------------------------
    logic [VW-1:0] above;
    logic          ram_we;

    assign ram_we = (state_reg == gmtn_pkg::ST_READ);

    gmtn_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_COLUMNS)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (v_reg),
        .raddr (col_reg),
        .rdata (above)
    );

    // ------------------------------------------------------------------
    // grid counters
    // ------------------------------------------------------------------
    logic [CW:0]                   cols_eff, col_inc;
    logic [gmtn_pkg::ROW_BITS-1:0] rows_eff, row_inc;

    always_comb
    begin
        if (grid_columns_reg == '0)
            cols_eff = (CW+1)'(1);
        else if (32'(grid_columns_reg) > 32'(MAX_COLUMNS))
            cols_eff = (CW+1)'(MAX_COLUMNS);
        else
            cols_eff = (CW+1)'(grid_columns_reg);

        if (grid_rows_reg == '0)
            rows_eff = gmtn_pkg::ROW_BITS'(1);
        else if (32'(grid_rows_reg) > 32'(gmtn_pkg::ROW_LIMIT))
            rows_eff = gmtn_pkg::ROW_BITS'(gmtn_pkg::ROW_LIMIT);
        else
            rows_eff = gmtn_pkg::ROW_BITS'(grid_rows_reg);

        col_inc = {1'b0, col_reg} + (CW+1)'(1);
        row_inc = row_reg + gmtn_pkg::ROW_BITS'(1);
    end

    // ------------------------------------------------------------------
    // shared multiplier operands
    // ------------------------------------------------------------------
    logic signed [D-1:0] va [3];
    logic signed [D-1:0] vb [3];
    logic [MW-1:0]       mag [3];
    logic signed [D:0]   mul_a, mul_b;
    logic signed [CXW-1:0] pc;
    logic [MW-1:0]         pu;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            va[j]  = nsel_reg ? g_reg[j] : e_reg[j];
            vb[j]  = nsel_reg ? e_reg[j] : f_reg[j];
            mag[j] = c_reg[j][CXW-1] ? MW'(-c_reg[j]) : MW'(c_reg[j]);
        end
    end

    always_comb
    begin
        case (cnt_reg)
            5'd0:    begin mul_a = {va[1][D-1], va[1]}; mul_b = {vb[2][D-1], vb[2]}; end
            5'd1:    begin mul_a = {va[2][D-1], va[2]}; mul_b = {vb[1][D-1], vb[1]}; end
            5'd2:    begin mul_a = {va[2][D-1], va[2]}; mul_b = {vb[0][D-1], vb[0]}; end
            5'd3:    begin mul_a = {va[0][D-1], va[0]}; mul_b = {vb[2][D-1], vb[2]}; end
            5'd4:    begin mul_a = {va[0][D-1], va[0]}; mul_b = {vb[1][D-1], vb[1]}; end
            5'd5:    begin mul_a = {va[1][D-1], va[1]}; mul_b = {vb[0][D-1], vb[0]}; end
            5'd7:    begin mul_a = {1'b0, mag[0][MW-1:D]}; mul_b = {1'b0, mag[0][MW-1:D]}; end
            5'd8:    begin mul_a = {1'b0, mag[0][MW-1:D]}; mul_b = {1'b0, mag[0][D-1:0]}; end
            5'd9:    begin mul_a = {1'b0, mag[0][D-1:0]};  mul_b = {1'b0, mag[0][D-1:0]}; end
            5'd10:   begin mul_a = {1'b0, mag[1][MW-1:D]}; mul_b = {1'b0, mag[1][MW-1:D]}; end
            5'd11:   begin mul_a = {1'b0, mag[1][MW-1:D]}; mul_b = {1'b0, mag[1][D-1:0]}; end
            5'd12:   begin mul_a = {1'b0, mag[1][D-1:0]};  mul_b = {1'b0, mag[1][D-1:0]}; end
            5'd13:   begin mul_a = {1'b0, mag[2][MW-1:D]}; mul_b = {1'b0, mag[2][MW-1:D]}; end
            5'd14:   begin mul_a = {1'b0, mag[2][MW-1:D]}; mul_b = {1'b0, mag[2][D-1:0]}; end
            5'd15:   begin mul_a = {1'b0, mag[2][D-1:0]};  mul_b = {1'b0, mag[2][D-1:0]}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign pc = prod_reg[CXW-1:0];
    assign pu = prod_reg[MW-1:0];

    // ------------------------------------------------------------------
    // rounding search: largest r with (2r-1)^2 * S <= 2^30 * c^2
    // ------------------------------------------------------------------
    logic signed [W-1:0] s_sum, cand;
    logic                cand_ok;
    logic [SB-1:0]       r_new;
    logic [NB-1:0]       r_ext;
    logic signed [NB-1:0] nrm_val;

    always_comb
    begin
        s_sum   = $signed(W'(sq_reg[0]) + W'(sq_reg[1]) + W'(sq_reg[2]));
        cand    = p_reg + a_reg + b_reg;
        cand_ok = (cand <= t_reg);
        r_new   = cand_ok ? (r_reg | (SB'(1) << kc_reg)) : r_reg;
        r_ext   = NB'(r_new);
        if (mag[comp_reg] == '0)
            nrm_val = '0;
        else if (c_reg[comp_reg][CXW-1])
            nrm_val = $signed(-r_ext);
        else
            nrm_val = $signed(r_ext);
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic in_acc, out_load;

    assign in_ready = (state_reg == gmtn_pkg::ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_load = (state_reg == gmtn_pkg::ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gmtn_pkg::ST_IDLE: if (in_acc) state_next = gmtn_pkg::ST_READ;
            gmtn_pkg::ST_READ: state_next = quad_reg ? gmtn_pkg::ST_MUL : gmtn_pkg::ST_IDLE;
            gmtn_pkg::ST_MUL:  if (cnt_reg == MUL_LAST) state_next = gmtn_pkg::ST_SRCH;
            gmtn_pkg::ST_SRCH:
                if (!srch_init_reg && kc_reg == '0 && comp_reg == 2'd2)
                    state_next = nsel_reg ? gmtn_pkg::ST_EMIT : gmtn_pkg::ST_MUL;
            gmtn_pkg::ST_EMIT:
                if (out_load && word_reg == gmtn_pkg::LAST_WORD)
                    state_next = gmtn_pkg::ST_IDLE;
            default: state_next = gmtn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gmtn_pkg::ST_IDLE;
            grid_columns_reg <= gmtn_pkg::GRID_COLUMNS_RST;
            grid_rows_reg    <= gmtn_pkg::GRID_ROWS_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            quad_reg         <= 1'b0;
            nsel_reg         <= 1'b0;
            cnt_reg          <= '0;
            comp_reg         <= '0;
            srch_init_reg    <= 1'b0;
            kc_reg           <= '0;
            word_reg         <= '0;
            out_valid_reg    <= 1'b0;
            left_reg         <= '0;
            upper_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we && cfg_index == gmtn_pkg::REG_GRID_COLUMNS)
                grid_columns_reg <= cfg_data;
            if (cfg_we && cfg_index == gmtn_pkg::REG_GRID_ROWS)
                grid_rows_reg <= cfg_data;

            case (state_reg)
                gmtn_pkg::ST_IDLE:
                begin
                    if (in_acc)
                        quad_reg <= (row_reg != '0) && (col_reg != '0);
                end
                gmtn_pkg::ST_READ:
                begin
                    upper_reg <= above;
                    left_reg  <= v_reg;
                    nsel_reg  <= 1'b0;
                    cnt_reg   <= '0;
                    word_reg  <= '0;
                    // advance; a counter past a shrunk limit wraps here
                    if (col_inc >= cols_eff)
                    begin
                        col_reg <= '0;
                        row_reg <= (row_inc >= rows_eff) ? '0 : row_inc;
                    end
                    else
                    begin
                        col_reg <= col_inc[CW-1:0];
                    end
                end
                gmtn_pkg::ST_MUL:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == MUL_LAST)
                    begin
                        comp_reg      <= '0;
                        srch_init_reg <= 1'b1;
                    end
                end
                gmtn_pkg::ST_SRCH:
                begin
                    if (srch_init_reg)
                    begin
                        srch_init_reg <= 1'b0;
                        kc_reg        <= 4'(SB - 1);
                    end
                    else if (kc_reg == '0)
                    begin
                        srch_init_reg <= 1'b1;
                        comp_reg      <= comp_reg + 2'd1;
                        if (comp_reg == 2'd2)
                        begin
                            nsel_reg <= 1'b1;
                            cnt_reg  <= '0;
                        end
                    end
                    else
                    begin
                        kc_reg <= kc_reg - 4'd1;
                    end
                end
                gmtn_pkg::ST_EMIT:
                begin
                    if (out_load)
                        word_reg <= word_reg + 3'd1;
                end
                default: ;
            endcase

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (in_acc)
            v_reg <= {vert_z, vert_y, vert_x};

        if (state_reg == gmtn_pkg::ST_READ)
        begin
            p0_reg <= upper_reg;
            p1_reg <= above;
            p3_reg <= left_reg;
            for (int j = 0; j < 3; j++)
            begin
                e_reg[j] <= D'($signed(v_reg[j*CB +: CB])) - D'($signed(upper_reg[j*CB +: CB]));
                f_reg[j] <= D'($signed(left_reg[j*CB +: CB])) - D'($signed(upper_reg[j*CB +: CB]));
                g_reg[j] <= D'($signed(above[j*CB +: CB])) - D'($signed(upper_reg[j*CB +: CB]));
            end
        end

        if (state_reg == gmtn_pkg::ST_MUL)
        begin
            if (cnt_reg == '0)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    c_reg[j]  <= '0;
                    sq_reg[j] <= '0;
                end
            end
            // consume the product issued last cycle
            case (cnt_reg)
                5'd1:  c_reg[0]  <= c_reg[0] + pc;
                5'd2:  c_reg[0]  <= c_reg[0] - pc;
                5'd3:  c_reg[1]  <= c_reg[1] + pc;
                5'd4:  c_reg[1]  <= c_reg[1] - pc;
                5'd5:  c_reg[2]  <= c_reg[2] + pc;
                5'd6:  c_reg[2]  <= c_reg[2] - pc;
                5'd8:  sq_reg[0] <= sq_reg[0] + (SQW'(pu) << (2*D));
                5'd9:  sq_reg[0] <= sq_reg[0] + (SQW'(pu) << (D+1));
                5'd10: sq_reg[0] <= sq_reg[0] + SQW'(pu);
                5'd11: sq_reg[1] <= sq_reg[1] + (SQW'(pu) << (2*D));
                5'd12: sq_reg[1] <= sq_reg[1] + (SQW'(pu) << (D+1));
                5'd13: sq_reg[1] <= sq_reg[1] + SQW'(pu);
                5'd14: sq_reg[2] <= sq_reg[2] + (SQW'(pu) << (2*D));
                5'd15: sq_reg[2] <= sq_reg[2] + (SQW'(pu) << (D+1));
                5'd16: sq_reg[2] <= sq_reg[2] + SQW'(pu);
                default: ;
            endcase
        end

        if (state_reg == gmtn_pkg::ST_SRCH)
        begin
            if (srch_init_reg)
            begin
                p_reg <= s_sum;
                a_reg <= -(s_sum <<< (SB + 1));
                b_reg <= s_sum <<< (2 * SB);
                t_reg <= $signed(W'(sq_reg[comp_reg]) << (2 * SB));
                r_reg <= '0;
            end
            else
            begin
                r_reg <= r_new;
                b_reg <= b_reg >>> 2;
                if (cand_ok)
                begin
                    p_reg <= cand;
                    a_reg <= (a_reg >>> 1) + b_reg;
                end
                else
                begin
                    a_reg <= a_reg >>> 1;
                end
                if (kc_reg == '0)
                    nrm_reg[nsel_reg][comp_reg] <= nrm_val;
            end
        end

        if (out_load)
        begin
            case (word_reg)
                3'd0:    {oz_reg, oy_reg, ox_reg} <= p0_reg;
                3'd1:    {oz_reg, oy_reg, ox_reg} <= v_reg;
                3'd2:    {oz_reg, oy_reg, ox_reg} <= p3_reg;
                3'd3:    {oz_reg, oy_reg, ox_reg} <= p0_reg;
                3'd4:    {oz_reg, oy_reg, ox_reg} <= p1_reg;
                default: {oz_reg, oy_reg, ox_reg} <= v_reg;
            endcase
            // first triangle carries n1, second n0
            if (word_reg < 3'd3)
            begin
                nx_reg <= nrm_reg[1][0];
                ny_reg <= nrm_reg[1][1];
                nz_reg <= nrm_reg[1][2];
            end
            else
            begin
                nx_reg <= nrm_reg[0][0];
                ny_reg <= nrm_reg[0][1];
                nz_reg <= nrm_reg[0][2];
            end
            done_reg <= (word_reg == gmtn_pkg::LAST_WORD);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = $signed(ox_reg);
    assign out_y     = $signed(oy_reg);
    assign out_z     = $signed(oz_reg);
    assign norm_x    = nx_reg;
    assign norm_y    = ny_reg;
    assign norm_z    = nz_reg;
    assign quad_done = done_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `GMTN_ASSERT_NEXT(a_accept_reads, in_valid && in_ready, state_reg == gmtn_pkg::ST_READ)
    `GMTN_ASSERT_NEXT(a_no_quad_idle, state_reg == gmtn_pkg::ST_READ && !quad_reg, state_reg == gmtn_pkg::ST_IDLE)
    `GMTN_ASSERT_SAME(a_mul_bound, state_reg == gmtn_pkg::ST_MUL, cnt_reg <= MUL_LAST && cnt_reg != MUL_SKIP || cnt_reg == MUL_SKIP)

endmodule

@@ sim/grid_mesh_triangulator_normals_tb.sv @@
// ----------------------------------------------------------------------------
// Grid mesh triangulator testbench
// Streams grid vertices through the triangulator under several grid sizes,
// predicts the six triangle words of every closed quad, including the exactly
// rounded Q1.14 face normals, and compares each output word in order. Both
// channels stall at random.
// ----------------------------------------------------------------------------
module grid_mesh_triangulator_normals_tb;

    localparam int  NCOL         = 1024;
    localparam int  CYCLE_LIMIT  = 300000;
    localparam int  RANDOM_ITEMS = 220;

    localparam logic [gmtn_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [gmtn_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vtx_t;

    typedef struct packed {
        longint x;
        longint y;
        longint z;
    } wide_t;

    typedef struct packed {
        vtx_t p;
        vtx_t n;
        logic done;
    } tri_word_t;

    typedef struct packed {
        vtx_t v;
        logic known;
        vtx_t n;
    } row_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_we;
    logic [gmtn_pkg::CFG_INDEX_BITS-1:0]  cfg_index;
    logic [gmtn_pkg::CFG_BITS-1:0]        cfg_data;
    logic                                 in_valid;
    logic                                 in_ready;
    logic signed [15:0]                   vert_x, vert_y, vert_z;
    logic                                 out_valid;
    logic                                 out_ready;
    logic signed [15:0]                   out_x, out_y, out_z;
    logic signed [15:0]                   norm_x, norm_y, norm_z;
    logic                                 quad_done;

    grid_mesh_triangulator_normals dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .quad_done(quad_done)
    );

    // shadow of the block
    logic [gmtn_pkg::CFG_BITS-1:0] mdl_cols, mdl_rows;
    vtx_t                line_buf [NCOL];
    vtx_t                left_v, upper_v;
    int unsigned         col_cnt, row_cnt;

    tri_word_t           pending_words[$];
    int                  errors = 0;
    int                  words_seen = 0;
    int                  quads_sent = 0;
    int                  items_sent = 0;
    int                  cycles = 0;
    logic                out_pressure = 1'b1;

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch %0d: %s", errors, what);
    endtask

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // exact round(16384 * c / |c|), ties away from zero
    function automatic vtx_t face_normal(input wide_t a, input wide_t b);
        longint          cc[3];
        logic [127:0]    s, rhs, lhs, m2, k;
        longint unsigned m;
        int unsigned     lo, hi, mid;
        logic signed [15:0] r[3];
        vtx_t            n;
        cc[0] = a.y * b.z - a.z * b.y;
        cc[1] = a.z * b.x - a.x * b.z;
        cc[2] = a.x * b.y - a.y * b.x;
        s = '0;
        for (int i = 0; i < 3; i++)
        begin
            m2 = 128'(magnitude(cc[i]));
            s  = s + m2 * m2;
        end
        for (int i = 0; i < 3; i++)
        begin
            m = magnitude(cc[i]);
            r[i] = '0;
            if (m != 0)
            begin
                m2  = 128'(m);
                rhs = (m2 * m2) << 30;
                lo  = 0;
                hi  = 16384;
                while (lo < hi)
                begin
                    mid = (lo + hi + 1) / 2;
                    k   = 128'(2 * mid - 1);
                    lhs = k * k * s;
                    if (lhs <= rhs)
                        lo = mid;
                    else
                        hi = mid - 1;
                end
                r[i] = (cc[i] < 0) ? -16'(lo) : 16'(lo);
            end
        end
        n.x = r[0];
        n.y = r[1];
        n.z = r[2];
        return n;
    endfunction

    function automatic wide_t diff(input vtx_t a, input vtx_t b);
        wide_t d;
        d.x = longint'(a.x) - longint'(b.x);
        d.y = longint'(a.y) - longint'(b.y);
        d.z = longint'(a.z) - longint'(b.z);
        return d;
    endfunction

    function automatic void push_word(input vtx_t p, input vtx_t n, input logic done);
        tri_word_t w;
        w.p = p;
        w.n = n;
        w.done = done;
        pending_words = {pending_words, w};
    endfunction

    // advance the shadow by one accepted vertex and queue its triangle words
    function automatic void triangulate(input vtx_t v, input logic known, input vtx_t kn);
        int unsigned cols, rows, col;
        vtx_t        above, n0, n1;
        cols = (mdl_cols < 1) ? 1 : (mdl_cols > NCOL) ? NCOL : mdl_cols;
        rows = (mdl_rows < 1) ? 1 :
               (mdl_rows > gmtn_pkg::ROW_LIMIT) ? gmtn_pkg::ROW_LIMIT : mdl_rows;
        col  = (col_cnt >= NCOL) ? 0 : col_cnt;
        above = line_buf[col];
        if (row_cnt > 0 && col > 0)
        begin
            n0 = face_normal(diff(v, upper_v), diff(left_v, upper_v));
            n1 = face_normal(diff(above, upper_v), diff(v, upper_v));
            if (known)
            begin
                n0 = kn;
                n1 = kn;
            end
            push_word(upper_v, n1, 1'b0);
            push_word(v,       n1, 1'b0);
            push_word(left_v,  n1, 1'b0);
            push_word(upper_v, n0, 1'b0);
            push_word(above,   n0, 1'b0);
            push_word(v,       n0, 1'b1);
            quads_sent++;
        end
        upper_v = above;
        line_buf[col] = v;
        left_v = v;
        col++;
        if (col >= cols)
        begin
            col = 0;
            row_cnt++;
            if (row_cnt >= rows)
                row_cnt = 0;
        end
        col_cnt = col;
    endfunction

    function automatic int unsigned grid_size();
        int unsigned cols, rows;
        cols = (mdl_cols < 1) ? 1 : (mdl_cols > NCOL) ? NCOL : mdl_cols;
        rows = (mdl_rows < 1) ? 1 :
               (mdl_rows > gmtn_pkg::ROW_LIMIT) ? gmtn_pkg::ROW_LIMIT : mdl_rows;
        return cols * rows;
    endfunction

    // called at a rising edge; returns at the edge that takes the word
    task automatic send_vertex(input vtx_t v, input logic known, input vtx_t kn);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        vert_x <= v.x;
        vert_y <= v.y;
        vert_z <= v.z;
        do @(posedge clk); while (!in_ready);
        triangulate(v, known, kn);
        items_sent++;
    endtask

    task automatic write_reg(input logic [gmtn_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [gmtn_pkg::CFG_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == gmtn_pkg::REG_GRID_COLUMNS)
            mdl_cols = val;
        else if (idx == gmtn_pkg::REG_GRID_ROWS)
            mdl_rows = val;
        @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (pending_words.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
    endtask

    function automatic vtx_t random_vertex();
        vtx_t v;
        case ($urandom_range(0, 7))
            0, 1:
            begin
                v.x = 16'($urandom);
                v.y = 16'($urandom);
                v.z = 16'($urandom);
            end
            2:       v = left_v;  // repeat the left corner: degenerate faces
            default:
            begin
                v.x = 16'($urandom_range(0, 400)) - 16'sd200;
                v.y = 16'($urandom_range(0, 400)) - 16'sd200;
                v.z = 16'($urandom_range(0, 400)) - 16'sd200;
            end
        endcase
        return v;
    endfunction

    task automatic send_grids(input int n_grids);
        vtx_t none;
        none = '0;
        for (int g = 0; g < n_grids; g++)
            for (int unsigned i = 0; i < grid_size(); i++)
                send_vertex(random_vertex(), 1'b0, none);
        drain();
    endtask

    task automatic send_count(input int n);
        vtx_t none;
        none = '0;
        for (int i = 0; i < n; i++)
            send_vertex(random_vertex(), 1'b0, none);
        drain();
    endtask

    // default grid is 2 x 2, so every fourth vertex closes a quad
    row_t directed [16] = '{
        '{'{16'sd0, 16'sd0, 16'sd0},             1'b0, '0},
        '{'{16'sd1, 16'sd0, 16'sd0},             1'b0, '0},
        '{'{16'sd0, 16'sd1, 16'sd0},             1'b0, '0},
        '{'{16'sd1, 16'sd1, 16'sd0},             1'b1, '{16'sd0, 16'sd0, 16'sd16384}},
        '{'{16'sd5, 16'sd5, 16'sd5},             1'b0, '0},
        '{'{16'sd5, 16'sd5, 16'sd5},             1'b0, '0},
        '{'{16'sd5, 16'sd5, 16'sd5},             1'b0, '0},
        '{'{16'sd5, 16'sd5, 16'sd5},             1'b1, '{16'sd0, 16'sd0, 16'sd0}},
        '{'{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0},
        '{'{16'sd32767, -16'sd32768, 16'sd32767},   1'b0, '0},
        '{'{-16'sd32768, 16'sd32767, -16'sd32768},  1'b0, '0},
        '{'{16'sd32767, 16'sd32767, 16'sd32767},    1'b0, '0},
        '{'{16'sd32767, 16'sd32767, 16'sd32767},    1'b0, '0},
        '{'{-16'sd32768, 16'sd32767, 16'sd0},       1'b0, '0},
        '{'{16'sd0, -16'sd32768, 16'sd32767},       1'b0, '0},
        '{'{-16'sd32768, -16'sd32768, 16'sd32767},  1'b0, '0}
    };

    // output side: random stalls per word, with bursts of none
    initial begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                out_pressure = ~out_pressure;
            stall = out_pressure ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        tri_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            words_seen++;
            if (pending_words.size() == 0)
                report($sformatf("unexpected word (%0d,%0d,%0d)", out_x, out_y, out_z));
            else
            begin
                w = pending_words.pop_front();
                if (out_x !== w.p.x || out_y !== w.p.y || out_z !== w.p.z ||
                    norm_x !== w.n.x || norm_y !== w.n.y || norm_z !== w.n.z ||
                    quad_done !== w.done)
                    report($sformatf({"got p(%0d,%0d,%0d) n(%0d,%0d,%0d) d%0b ",
                                      "exp p(%0d,%0d,%0d) n(%0d,%0d,%0d) d%0b"},
                        out_x, out_y, out_z, norm_x, norm_y, norm_z, quad_done,
                        w.p.x, w.p.y, w.p.z, w.n.x, w.n.y, w.n.z, w.done));
            end
        end
    end

    initial begin
        int guard;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = gmtn_pkg::REG_GRID_COLUMNS;
        cfg_data  = '0;
        in_valid  = 1'b0;
        vert_x    = '0;
        vert_y    = '0;
        vert_z    = '0;
        mdl_cols  = gmtn_pkg::GRID_COLUMNS_RST;
        mdl_rows  = gmtn_pkg::GRID_ROWS_RST;
        for (int i = 0; i < NCOL; i++)
            line_buf[i] = '0;
        left_v  = '0;
        upper_v = '0;
        col_cnt = 0;
        row_cnt = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_vertex(directed[i].v, directed[i].known, directed[i].n);
        drain();

        // saturating and ignored writes
        write_reg(gmtn_pkg::REG_GRID_COLUMNS, 11'd0);
        write_reg(gmtn_pkg::REG_GRID_ROWS, 11'd3);
        write_reg(REG_SPARE_LO, 11'h7ff);
        write_reg(REG_SPARE_HI, 11'h5a5);
        send_grids(2);

        // oversized width holds the full line buffer: no wrap within the run
        write_reg(gmtn_pkg::REG_GRID_COLUMNS, 11'h7ff);
        write_reg(gmtn_pkg::REG_GRID_ROWS, 11'd0);
        send_count(20);
        // shrink mid-row: the column counter wraps on the next advance
        write_reg(gmtn_pkg::REG_GRID_COLUMNS, 11'd2);
        write_reg(gmtn_pkg::REG_GRID_ROWS, 11'd2);
        send_count(3);

        // oversized height, then shrink: the row counter wraps on the next advance
        write_reg(gmtn_pkg::REG_GRID_COLUMNS, 11'd1);
        write_reg(gmtn_pkg::REG_GRID_ROWS, 11'h7ff);
        send_count(12);
        write_reg(gmtn_pkg::REG_GRID_ROWS, 11'd2);
        send_count(1);

        write_reg(gmtn_pkg::REG_GRID_COLUMNS, 11'd24);
        write_reg(gmtn_pkg::REG_GRID_ROWS, 11'd3);
        send_grids(1);

        guard = items_sent + RANDOM_ITEMS;
        while (items_sent < guard)
        begin
            write_reg(gmtn_pkg::REG_GRID_COLUMNS, 11'($urandom_range(1, 8)));
            write_reg(gmtn_pkg::REG_GRID_ROWS, 11'($urandom_range(1, 6)));
            send_grids($urandom_range(1, 3));
        end

        $display("sent %0d vertices, %0d quads; checked %0d triangle words",
                 items_sent, quads_sent, words_seen);
        $display("grids 1 to 24 wide, saturated width and height, mid-row shrinks, ignored writes");
        if (errors == 0 && pending_words.size() == 0)
            $display("RESULT: OK");
        else
        begin
            $display("%0d mismatches, %0d words never arrived", errors, pending_words.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
